[rtl/fgn_pkg.sv]
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared widths, control types and the gradient function of the noise block.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int CoordFracBits = 16;
  localparam int MaxOctaves    = 8;
  localparam int FadeW         = 17;

  typedef enum logic [1:0] {
    CFG_OCTAVE_COUNT = 2'd0,
    CFG_PERSIST      = 2'd1,
    CFG_SCALE        = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OCT,
    ST_SCALE,
    ST_DONE
  } state_e;

  function automatic logic signed [19:0] fgn_grad(logic [1:0] h, logic signed [17:0] dx,
                                                  logic signed [17:0] dy);
    logic signed [19:0] u;
    logic signed [19:0] v;
    logic signed [19:0] a;
    logic signed [19:0] b;
    u = h[1] ? 20'(dy) : 20'(dx);
    v = h[1] ? 20'(dx) : 20'(dy);
    a = h[0] ? -u : u;
    b = h[1] ? -(v <<< 1) : (v <<< 1);
    return a + b;
  endfunction

endpackage

[rtl/fgn_fade.sv]
// ----------------------------------------------------------------------------
// fgn_fade
// Three-stage quintic fade curve on a Q0.16 fraction, result in Q1.16.
// ----------------------------------------------------------------------------
module fgn_fade import fgn_pkg::*; (
  input  logic             clk_i,
  input  logic [15:0]      t_i,
  output logic [FadeW-1:0] fade_o
);

  logic [15:0] t1_q;
  logic [31:0] sq_q;
  logic [15:0] c_q;
  logic [20:0] q16_q;
  logic [FadeW-1:0] fade_q;
  logic [47:0] cube;
  logic [36:0] q;
  logic [36:0] f;

  always_comb begin
    cube = 48'(sq_q) * 48'(t1_q);
    q    = 37'(sq_q) * 37'd6 + (37'd10 << 32) - ((37'(t1_q) * 37'd15) << 16);
    f    = 37'(c_q) * 37'(q16_q);
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= t_i;
    sq_q   <= 32'(t_i) * 32'(t_i);
    c_q    <= cube[47:32];
    q16_q  <= q[36:16];
    fade_q <= f[FadeW+15:16];
  end

  assign fade_o = fade_q;

endmodule

[rtl/fractal_gradient_noise.sv]
// ----------------------------------------------------------------------------
// fractal_gradient_noise
// Fractal Perlin noise over octaves with a permutation table read through one port.
// An evaluate item runs ST_OCT once per octave, then ST_SCALE and ST_DONE; its
// height is registered once the output is free, and in_stall_o holds the next
// item off until ST_IDLE. A load item stays in ST_IDLE. The octave sequencer
// and the single table read port set the rate (six table reads per octave).
// Reset idles control and loads default configuration; the table is undefined.
// ----------------------------------------------------------------------------
module fractal_gradient_noise import fgn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic [23:0]        coord_x_i,
  input  logic [23:0]        coord_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] height_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i
);

  localparam logic [3:0] LastStep = 4'd12;

  state_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [2:0]  oct_q, oct_d;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  octave_count_q;
  logic [1:0]  persist_q;
  logic [17:0] scale_q;

  logic [7:0]  table_mem [256];
  logic [7:0]  rdata_q;
  logic [7:0]  raddr;
  logic        accept, tbl_we, last_oct, out_free;
  logic [3:0]  n_oct;

  logic [23:0] cx_q, cy_q;
  logic [7:0]  xi_q, yi_q, pa_q, pb_q;
  logic [15:0] xf_q, yf_q;
  logic [1:0]  haa_q, hab_q, hba_q, hbb_q;
  logic signed [19:0] g1_q, g2_q;
  logic signed [20:0] d1_q, d2_q;
  logic signed [21:0] x1_q, x2_q;
  logic signed [22:0] d3_q;
  logic signed [23:0] n_q;
  logic signed [25:0] sum_q;
  logic signed [44:0] prod_q;
  logic signed [15:0] height_q;

  logic [31:0] sx, sy;
  logic [FadeW-1:0] fu, fv;
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [19:0] gaa, gab, gba, gbb;
  logic signed [38:0] p1, p2;
  logic signed [40:0] p3;
  logic [4:0]  shamt;
  logic signed [23:0] n_sh;
  logic signed [24:0] h_full;
  logic signed [15:0] h_sat;

  fgn_fade u_fade_x (.clk_i(clk_i), .t_i(xf_q), .fade_o(fu));
  fgn_fade u_fade_y (.clk_i(clk_i), .t_i(yf_q), .fade_o(fv));

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign tbl_we      = accept && cmd_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign height_o    = height_q;
  assign out_free    = !(out_valid_q && out_stall_i);
  assign n_oct       = (octave_count_q > 4'(MaxOctaves)) ? 4'(MaxOctaves) : octave_count_q;
  assign last_oct    = ({1'b0, oct_q} + 4'd1) == n_oct;

  always_comb begin
    sx  = 32'(cx_q) << oct_q;
    sy  = 32'(cy_q) << oct_q;
    dx0 = $signed({2'b00, xf_q});
    dy0 = $signed({2'b00, yf_q});
    dx1 = dx0 - 18'sd65536;
    dy1 = dy0 - 18'sd65536;
    gaa = fgn_grad(haa_q, dx0, dy0);
    gba = fgn_grad(hba_q, dx1, dy0);
    gab = fgn_grad(hab_q, dx0, dy1);
    gbb = fgn_grad(hbb_q, dx1, dy1);
    p1  = $signed({1'b0, fu}) * d1_q;
    p2  = $signed({1'b0, fu}) * d2_q;
    p3  = $signed({1'b0, fv}) * d3_q;
    shamt = 5'(persist_q) * 5'(oct_q);
    n_sh  = n_q >>> shamt;
    h_full = prod_q[44:20];
    if (h_full > 25'sd32767) begin
      h_sat = 16'sh7fff;
    end else if (h_full < -25'sd32768) begin
      h_sat = -16'sh8000;
    end else begin
      h_sat = h_full[15:0];
    end
  end

  always_comb begin
    case (step_q)
      4'd2:    raddr = xi_q + 8'd1;
      4'd3:    raddr = pa_q + yi_q;
      4'd4:    raddr = pa_q + yi_q + 8'd1;
      4'd5:    raddr = pb_q + yi_q;
      4'd6:    raddr = pb_q + yi_q + 8'd1;
      default: raddr = xi_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_mem[table_index_i] <= table_value_i;
    end
    rdata_q <= table_mem[raddr];
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    oct_d       = oct_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !cmd_i) begin
          step_d  = 4'd0;
          oct_d   = 3'd0;
          state_d = (n_oct == 4'd0) ? ST_SCALE : ST_OCT;
        end
      end
      ST_OCT: begin
        if (step_q == LastStep) begin
          step_d = 4'd0;
          if (last_oct) begin
            state_d = ST_SCALE;
          end else begin
            oct_d = oct_q + 3'd1;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_SCALE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= 4'd0;
      oct_q          <= 3'd0;
      out_valid_q    <= 1'b0;
      octave_count_q <= 4'd4;
      persist_q      <= 2'd1;
      scale_q        <= 18'd41943;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      oct_q       <= oct_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_OCTAVE_COUNT: octave_count_q <= cfg_data_i[3:0];
          CFG_PERSIST:      persist_q      <= cfg_data_i[1:0];
          CFG_SCALE:        scale_q        <= cfg_data_i;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q  <= coord_x_i;
      cy_q  <= coord_y_i;
      sum_q <= '0;
    end
    if (state_q == ST_OCT) begin
      case (step_q)
        4'd0: begin
          xi_q <= sx[CoordFracBits+7:CoordFracBits];
          yi_q <= sy[CoordFracBits+7:CoordFracBits];
          xf_q <= sx[CoordFracBits-1:0];
          yf_q <= sy[CoordFracBits-1:0];
        end
        4'd2: pa_q  <= rdata_q;
        4'd3: pb_q  <= rdata_q;
        4'd4: haa_q <= rdata_q[1:0];
        4'd5: hab_q <= rdata_q[1:0];
        4'd6: hba_q <= rdata_q[1:0];
        4'd7: hbb_q <= rdata_q[1:0];
        4'd8: begin
          g1_q <= gaa;
          g2_q <= gab;
          d1_q <= 21'(gba) - 21'(gaa);
          d2_q <= 21'(gbb) - 21'(gab);
        end
        4'd9: begin
          x1_q <= 22'(g1_q) + p1[37:16];
          x2_q <= 22'(g2_q) + p2[37:16];
        end
        4'd10: d3_q <= 23'(x2_q) - 23'(x1_q);
        4'd11: n_q  <= 24'(x1_q) + p3[39:16];
        4'd12: sum_q <= sum_q + 26'(n_sh);
        default: ;
      endcase
    end
    if (state_q == ST_SCALE) begin
      prod_q <= 45'(sum_q) * 45'($signed({1'b0, scale_q}));
    end
    if (state_q == ST_DONE && out_free) begin
      height_q <= h_sat;
    end
  end

endmodule
